/* design/fixed_block_pool_allocator_defines.svh */
// Assertion macros used by the pool allocator top level.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define FBPA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define FBPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/fbpa_pkg.sv */
// Shared types and constants of the fixed block pool allocator.
package fbpa_pkg;

  localparam int unsigned NUM_BLOCKS_DEF  = 32;
  localparam int unsigned BLOCK_BYTES_DEF = 64;
  localparam int unsigned QUEUE_DEPTH     = 2;
  localparam int unsigned SCAN_LANES      = 8;

  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned STAT_W    = 32;
  localparam int unsigned CNT_OUT_W = 6;
  localparam int unsigned IDX_OUT_W = 5;

  localparam logic [ADDR_W-1:0] POOL_BASE_RST = 32'h2000_0000;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOBLOCK = 2'd2
  } fbpa_status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } fbpa_cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WORK,
    BK_DONE
  } fbpa_bk_state_t;

  // A request after classification by the front end.
  typedef struct packed {
    fbpa_cmd_t         cmd;
    logic              nonnull;
    logic              in_range;
    logic [ADDR_W-1:0] off;
  } fbpa_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fbpa_qstat_t;

  typedef struct packed {
    fbpa_status_t         status;
    logic [ADDR_W-1:0]    block_addr;
    logic [IDX_OUT_W-1:0] block_index;
    logic                 addr_ok;
    logic [CNT_OUT_W-1:0] blocks_used;
    logic [CNT_OUT_W-1:0] blocks_free;
    logic [CNT_OUT_W-1:0] blocks_peak;
    logic [STAT_W-1:0]    alloc_total;
    logic [STAT_W-1:0]    free_total;
    logic [STAT_W-1:0]    fail_total;
  } fbpa_result_t;

endpackage

/* design/fbpa_ifs.sv */
// Request and result channel interfaces of the pool allocator.
interface fbpa_req_if;
  import fbpa_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [ADDR_W-1:0] addr;

  modport source (output valid, cmd, addr, input ready);
  modport sink (input valid, cmd, addr, output ready);
endinterface

interface fbpa_rsp_if;
  import fbpa_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [ADDR_W-1:0]    block_addr;
  logic [IDX_OUT_W-1:0] block_index;
  logic                 addr_ok;
  logic [CNT_OUT_W-1:0] blocks_used;
  logic [CNT_OUT_W-1:0] blocks_free;
  logic [CNT_OUT_W-1:0] blocks_peak;
  logic [STAT_W-1:0]    alloc_total;
  logic [STAT_W-1:0]    free_total;
  logic [STAT_W-1:0]    fail_total;

  modport source (
    output valid, status, block_addr, block_index, addr_ok, blocks_used,
           blocks_free, blocks_peak, alloc_total, free_total, fail_total,
    input  ready
  );
  modport sink (
    input  valid, status, block_addr, block_index, addr_ok, blocks_used,
           blocks_free, blocks_peak, alloc_total, free_total, fail_total,
    output ready
  );
endinterface

/* design/fbpa_front.sv */
// Front end: takes requests and classifies the address against the pool.
module fbpa_front #(
  parameter int unsigned NUM_BLOCKS  = fbpa_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned BLOCK_BYTES = fbpa_pkg::BLOCK_BYTES_DEF
) (
  input  logic [fbpa_pkg::ADDR_W-1:0] pool_base,
  fbpa_req_if.sink                    req,
  input  fbpa_pkg::fbpa_qstat_t       q_stat,
  output logic                        push,
  output fbpa_pkg::fbpa_item_t        push_item
);
  import fbpa_pkg::*;

  localparam logic [ADDR_W:0] SPAN = (ADDR_W+1)'(NUM_BLOCKS * BLOCK_BYTES);

  logic [ADDR_W-1:0] off;

  // The offset wraps modulo 2^32, so a pool past the top of memory continues at 0.
  assign off = req.addr - pool_base;

  assign req.ready = !q_stat.full;
  assign push      = req.valid && !q_stat.full;

  assign push_item.cmd      = fbpa_cmd_t'(req.cmd);
  assign push_item.nonnull  = (req.addr != '0);
  assign push_item.in_range = ({1'b0, off} < SPAN);
  assign push_item.off      = off;
endmodule

/* design/fbpa_queue.sv */
// Short queue of classified requests between the front and back ends.
module fbpa_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  fbpa_pkg::fbpa_item_t  push_item,
  input  logic                  pop,
  output fbpa_pkg::fbpa_item_t  pop_item,
  output fbpa_pkg::fbpa_qstat_t q_stat
);
  import fbpa_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  fbpa_item_t       slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  assign pop_item     = slots[rd_ptr];
  assign q_stat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
endmodule

/* design/fbpa_back.sv */
// Back end: block index computation, bitmap scan, pool state and result register.
module fbpa_back #(
  parameter int unsigned NUM_BLOCKS  = fbpa_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned BLOCK_BYTES = fbpa_pkg::BLOCK_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [fbpa_pkg::ADDR_W-1:0] pool_base,
  input  fbpa_pkg::fbpa_qstat_t       q_stat,
  input  fbpa_pkg::fbpa_item_t        pop_item,
  output logic                        pop,
  fbpa_rsp_if.source                  rsp
);
  import fbpa_pkg::*;

  localparam int unsigned IDX_W     = $clog2(NUM_BLOCKS);
  localparam int unsigned CNT_W     = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned SPAN_W    = $clog2(NUM_BLOCKS * BLOCK_BYTES);
  localparam int unsigned NGRP      = (NUM_BLOCKS + SCAN_LANES - 1) / SCAN_LANES;
  localparam int unsigned GRP_W     = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int unsigned LANE_W    = $clog2(SCAN_LANES);
  localparam int unsigned MAP_W     = NGRP * SCAN_LANES;
  localparam int unsigned DIV_STEPS = 2;
  localparam int unsigned DSTEP_W   = 2;
  // Reciprocal that divides every in-pool offset exactly by the block size.
  localparam int unsigned LOG_B     = $clog2(BLOCK_BYTES);
  localparam int unsigned RSH       = SPAN_W + LOG_B;
  localparam int unsigned PROD_W    = 2 * SPAN_W + 2;
  localparam longint unsigned RECIP =
    ((64'd1 << RSH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);

  fbpa_bk_state_t    state;
  fbpa_bk_state_t    state_next;
  fbpa_item_t        item;
  logic [SPAN_W-1:0] rem;
  logic [IDX_W-1:0]  quo;
  logic [DSTEP_W-1:0] dstep;
  logic [GRP_W-1:0]  grp;
  logic              scan_done;
  logic              scan_found;
  logic [IDX_W-1:0]  found_idx;
  logic [NUM_BLOCKS-1:0] used_map;
  logic [CNT_W-1:0]  used_count;
  logic [CNT_W-1:0]  peak_count;
  logic [STAT_W-1:0] alloc_cnt;
  logic [STAT_W-1:0] free_cnt;
  logic [STAT_W-1:0] fail_cnt;
  logic              out_valid;
  fbpa_result_t      res;

  logic              commit;
  logic              div_fin;
  logic [PROD_W-1:0] prod;
  logic [MAP_W-1:0]  map_pad;
  logic [SCAN_LANES-1:0] grp_bits;
  logic              lane_hit;
  logic [LANE_W-1:0] lane;
  logic              addr_ok;
  logic              set_bit;
  logic              clr_bit;
  fbpa_status_t      status;
  logic [ADDR_W-1:0] baddr;
  logic [IDX_W-1:0]  bidx;
  logic [CNT_W-1:0]  used_next;
  logic [CNT_W-1:0]  peak_next;
  logic [STAT_W-1:0] alloc_next;
  logic [STAT_W-1:0] free_next;
  logic [STAT_W-1:0] fail_next;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          state_next = BK_WORK;
        end
      end
      BK_WORK: begin
        if (div_fin && scan_done) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid || rsp.ready) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    pop    = 1'b0;
    commit = 1'b0;
    unique case (state)
      BK_IDLE: pop    = !q_stat.empty;
      BK_WORK: ;
      BK_DONE: commit = !out_valid || rsp.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The quotient comes from a reciprocal product, the remainder from the registered quotient in the next cycle.
  assign div_fin = (dstep == DSTEP_W'(DIV_STEPS));
  assign prod    = PROD_W'(item.off[SPAN_W-1:0]) * PROD_W'(RECIP);

  // Blocks past the end of the pool read as used so the scan never picks them.
  always_comb begin
    map_pad = '1;
    map_pad[NUM_BLOCKS-1:0] = used_map;
  end

  assign grp_bits = map_pad[grp * SCAN_LANES +: SCAN_LANES];

  always_comb begin
    lane_hit = 1'b0;
    lane     = '0;
    for (int i = SCAN_LANES - 1; i >= 0; i--) begin
      if (!grp_bits[i]) begin
        lane_hit = 1'b1;
        lane     = LANE_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item       <= pop_item;
      quo        <= '0;
      dstep      <= '0;
      grp        <= '0;
      scan_done  <= (pop_item.cmd == CMD_FREE);
      scan_found <= 1'b0;
    end else if (state == BK_WORK) begin
      if (!div_fin) begin
        if (dstep == '0) begin
          quo <= IDX_W'(prod >> RSH);
        end else begin
          rem <= item.off[SPAN_W-1:0] - SPAN_W'(quo * BLOCK_BYTES);
        end
        dstep <= dstep + 1'b1;
      end
      if (!scan_done) begin
        if (lane_hit) begin
          scan_done  <= 1'b1;
          scan_found <= 1'b1;
          found_idx  <= IDX_W'({grp, lane});
        end else if (grp == GRP_W'(NGRP - 1)) begin
          scan_done <= 1'b1;
        end else begin
          grp <= grp + 1'b1;
        end
      end
    end
  end

  // Outcome of the request once the index and the scan are known.
  always_comb begin
    addr_ok    = item.nonnull && item.in_range && (rem == '0);
    set_bit    = 1'b0;
    clr_bit    = 1'b0;
    status     = ST_OK;
    baddr      = '0;
    bidx       = '0;
    used_next  = used_count;
    alloc_next = alloc_cnt;
    free_next  = free_cnt;
    fail_next  = fail_cnt;
    unique case (item.cmd)
      CMD_ALLOC: begin
        if (scan_found) begin
          set_bit    = 1'b1;
          used_next  = used_count + 1'b1;
          alloc_next = alloc_cnt + 1'b1;
          bidx       = found_idx;
          baddr      = pool_base + ADDR_W'(found_idx) * ADDR_W'(BLOCK_BYTES);
        end else begin
          status    = ST_NOBLOCK;
          fail_next = fail_cnt + 1'b1;
        end
      end
      CMD_FREE: begin
        priority if (!addr_ok) begin
          status = ST_INVALID;
        end else if (!used_map[quo]) begin
          // Covers a double free: the block is well formed but not in use.
          status = ST_INVALID;
          bidx   = quo;
        end else begin
          clr_bit   = 1'b1;
          used_next = used_count - 1'b1;
          free_next = free_cnt + 1'b1;
          bidx      = quo;
        end
      end
      default: ;
    endcase
    peak_next = (used_next > peak_count) ? used_next : peak_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used_map   <= '0;
      used_count <= '0;
      peak_count <= '0;
      alloc_cnt  <= '0;
      free_cnt   <= '0;
      fail_cnt   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (commit) begin
        if (set_bit) begin
          used_map[found_idx] <= 1'b1;
        end
        if (clr_bit) begin
          used_map[quo] <= 1'b0;
        end
        used_count <= used_next;
        peak_count <= peak_next;
        alloc_cnt  <= alloc_next;
        free_cnt   <= free_next;
        fail_cnt   <= fail_next;
        out_valid  <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      res.status      <= status;
      res.block_addr  <= baddr;
      res.block_index <= IDX_OUT_W'(bidx);
      res.addr_ok     <= addr_ok;
      res.blocks_used <= CNT_OUT_W'(used_next);
      res.blocks_free <= CNT_OUT_W'(CNT_W'(NUM_BLOCKS) - used_next);
      res.blocks_peak <= CNT_OUT_W'(peak_next);
      res.alloc_total <= alloc_next;
      res.free_total  <= free_next;
      res.fail_total  <= fail_next;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = res.status;
  assign rsp.block_addr  = res.block_addr;
  assign rsp.block_index = res.block_index;
  assign rsp.addr_ok     = res.addr_ok;
  assign rsp.blocks_used = res.blocks_used;
  assign rsp.blocks_free = res.blocks_free;
  assign rsp.blocks_peak = res.blocks_peak;
  assign rsp.alloc_total = res.alloc_total;
  assign rsp.free_total  = res.free_total;
  assign rsp.fail_total  = res.fail_total;
endmodule

/* design/fixed_block_pool_allocator.sv */
// Flow: a transferred request waits in the two-entry queue, then the back end works on it through
// the two-step index computation and, for an allocate, a scan of the 8-block bitmap groups up to
// the first free one (all groups are scanned when the pool is full) before the result register.
// The back end works on one request at a time; a stalled result adds its stall, and the two-entry
// queue keeps taking transfers meanwhile.
// Reset (rst, synchronous) frees every block, clears all counters, sets pool_base to 0x20000000.
`include "fixed_block_pool_allocator_defines.svh"

module fixed_block_pool_allocator #(
  parameter int unsigned NUM_BLOCKS  = fbpa_pkg::NUM_BLOCKS_DEF,
  parameter int unsigned BLOCK_BYTES = fbpa_pkg::BLOCK_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [fbpa_pkg::ADDR_W-1:0] cfg_data,
  fbpa_req_if.sink                    req,
  fbpa_rsp_if.source                  rsp
);
  import fbpa_pkg::*;

  logic [ADDR_W-1:0] pool_base;
  logic              push;
  logic              pop;
  fbpa_item_t        push_item;
  fbpa_item_t        pop_item;
  fbpa_qstat_t       q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= POOL_BASE_RST;
    end else if (cfg_we) begin
      pool_base <= cfg_data;
    end
  end

  fbpa_front #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_front (
    .pool_base (pool_base),
    .req       (req),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  fbpa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  fbpa_back #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pool_base (pool_base),
    .q_stat    (q_stat),
    .pop_item  (pop_item),
    .pop       (pop),
    .rsp       (rsp)
  );

  `FBPA_ASSERT_IMPL(a_count_sum, rsp.valid,
    CNT_OUT_W'(rsp.blocks_used + rsp.blocks_free) == CNT_OUT_W'(NUM_BLOCKS),
    "used and free counts do not add up to the pool size")
  `FBPA_ASSERT_IMPL(a_noblock_full, rsp.valid && rsp.status == ST_NOBLOCK,
    rsp.blocks_used == CNT_OUT_W'(NUM_BLOCKS), "allocate failed while blocks were free")
  `FBPA_ASSERT_IMPL(a_noblock_zero, rsp.valid && rsp.status == ST_NOBLOCK,
    rsp.block_addr == '0 && rsp.block_index == '0, "failed allocate returned a block")
  `FBPA_ASSERT_NEXT(a_one_in_work, pop, !pop, "back end took a second request while one is in work")
endmodule

/* tb/tb_fixed_block_pool_allocator.sv */
// Self-checking testbench for the fixed block pool allocator: directed table, then random phases.
`timescale 1ns / 100ps

module tb_fixed_block_pool_allocator;
  import fbpa_pkg::*;

  localparam int unsigned NBLK = NUM_BLOCKS_DEF;
  localparam int unsigned BLK_BYTES = BLOCK_BYTES_DEF;
  localparam logic [31:0] POOL_SPAN = NBLK * BLK_BYTES;

  typedef struct {
    fbpa_cmd_t    cmd;
    logic [31:0]  addr;
    bit           typed;
    fbpa_result_t res;
  } req_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_data;
  bit          no_stall;
  int          errors;

  fbpa_req_if req_bus ();
  fbpa_rsp_if rsp_bus ();

  fixed_block_pool_allocator u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_bus),
    .rsp      (rsp_bus)
  );

  // Shadow of the allocator state.
  logic [NBLK-1:0] blk_used;
  logic [5:0]      used_cnt;
  logic [5:0]      peak_cnt;
  logic [31:0]     n_alloc;
  logic [31:0]     n_freed;
  logic [31:0]     n_failed;
  logic [31:0]     pool_base;

  fbpa_result_t pending_results[$];
  fbpa_result_t oldest;
  req_row_t     script[$];

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  // Applies one request to the shadow state and returns the result it should produce.
  function automatic fbpa_result_t pool_apply(fbpa_cmd_t cmd, logic [31:0] addr);
    fbpa_result_t r;
    logic [31:0]  off;
    logic [31:0]  idx;
    logic         ok;
    int           slot;
    off = addr - pool_base;
    ok = (addr != 32'd0) && (off < POOL_SPAN) && (off % BLK_BYTES == 0);
    idx = off / BLK_BYTES;
    r = '0;
    r.status = ST_OK;
    r.addr_ok = ok;
    if (cmd == CMD_ALLOC) begin
      slot = -1;
      for (int i = NBLK - 1; i >= 0; i--) begin
        if (!blk_used[i]) slot = i;
      end
      if (slot >= 0) begin
        blk_used[slot] = 1'b1;
        used_cnt++;
        n_alloc++;
        if (used_cnt > peak_cnt) peak_cnt = used_cnt;
        r.block_index = slot[4:0];
        r.block_addr = pool_base + 32'(slot) * BLK_BYTES;
      end else begin
        r.status = ST_NOBLOCK;
        n_failed++;
      end
    end else if (!ok) begin
      r.status = ST_INVALID;
    end else begin
      r.block_index = idx[4:0];
      if (!blk_used[idx]) begin
        r.status = ST_INVALID;
      end else begin
        blk_used[idx] = 1'b0;
        used_cnt--;
        n_freed++;
      end
    end
    r.blocks_used = used_cnt;
    r.blocks_free = 6'(NBLK - used_cnt);
    r.blocks_peak = peak_cnt;
    r.alloc_total = n_alloc;
    r.free_total = n_freed;
    r.fail_total = n_failed;
    return r;
  endfunction

  function automatic fbpa_result_t known_result(fbpa_status_t st, logic [31:0] baddr,
                                                logic [4:0] bidx, logic ok, logic [5:0] used,
                                                logic [5:0] peak, logic [31:0] na,
                                                logic [31:0] nf, logic [31:0] nfl);
    fbpa_result_t r;
    r.status = st;
    r.block_addr = baddr;
    r.block_index = bidx;
    r.addr_ok = ok;
    r.blocks_used = used;
    r.blocks_free = 6'(NBLK - used);
    r.blocks_peak = peak;
    r.alloc_total = na;
    r.free_total = nf;
    r.fail_total = nfl;
    return r;
  endfunction

  // Presents one request and returns at the edge where the transfer happens.
  task automatic send_request(fbpa_cmd_t cmd, logic [31:0] addr, bit typed,
                              fbpa_result_t typed_res);
    fbpa_result_t predicted;
    req_bus.valid <= 1'b1;
    req_bus.cmd <= cmd;
    req_bus.addr <= addr;
    do @(posedge clk); while (!req_bus.ready);
    predicted = pool_apply(cmd, addr);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic drain_results();
    req_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input logic [31:0] base, input int n_items, input bit calm_tail);
    int          mode;
    int          seg_left;
    int          gap_pct;
    int          pick;
    int          k;
    int          used_idx[$];
    fbpa_cmd_t   cmd;
    logic [31:0] addr;
    drain_results();
    cfg_we <= 1'b1;
    cfg_data <= base;
    pool_base = base;
    @(posedge clk);
    cfg_we <= 1'b0;
    seg_left = 0;
    for (int n = 0; n < n_items; n++) begin
      // Segments lean toward filling the pool, emptying it, or neither.
      if (seg_left == 0) begin
        mode = $urandom_range(0, 2);
        seg_left = $urandom_range(20, 60);
        gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30);
      end
      seg_left--;
      if (calm_tail && n >= n_items - 150) no_stall = 1'b1;
      case (mode)
        0: cmd = ($urandom_range(0, 99) < 75) ? CMD_ALLOC : CMD_FREE;
        1: cmd = ($urandom_range(0, 99) < 25) ? CMD_ALLOC : CMD_FREE;
        default: cmd = ($urandom_range(0, 1) == 0) ? CMD_ALLOC : CMD_FREE;
      endcase
      k = $urandom_range(0, NBLK - 1);
      if (cmd == CMD_ALLOC) begin
        addr = ($urandom_range(0, 1) == 0) ? $urandom : pool_base + 32'(k) * BLK_BYTES;
      end else begin
        used_idx.delete();
        for (int i = 0; i < NBLK; i++) begin
          if (blk_used[i]) used_idx.push_back(i);
        end
        pick = $urandom_range(0, 99);
        if (pick < 55 && used_idx.size() > 0) begin
          k = used_idx[$urandom_range(0, used_idx.size() - 1)];
          addr = pool_base + 32'(k) * BLK_BYTES;
        end else if (pick < 70) begin
          addr = pool_base + 32'(k) * BLK_BYTES;
        end else if (pick < 80) begin
          case ($urandom_range(0, 2))
            0: addr = pool_base + 32'(k) * BLK_BYTES + $urandom_range(1, BLK_BYTES - 1);
            1: addr = pool_base + POOL_SPAN;
            default: addr = pool_base - $urandom_range(1, 4) * BLK_BYTES;
          endcase
        end else if (pick < 85) begin
          addr = 32'd0;
        end else begin
          addr = $urandom;
        end
      end
      send_request(cmd, addr, 1'b0, '0);
      if (!no_stall && $urandom_range(0, 99) < gap_pct) begin
        req_bus.valid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else if (!no_stall && $urandom_range(0, 199) == 0) begin
        drain_results();
      end
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got status %0d block_addr %h",
                 $time, rsp_bus.status, rsp_bus.block_addr);
      end else begin
        oldest = pending_results.pop_front();
        check_field("status", 32'(oldest.status), 32'(rsp_bus.status));
        check_field("block_addr", oldest.block_addr, rsp_bus.block_addr);
        check_field("block_index", 32'(oldest.block_index), 32'(rsp_bus.block_index));
        check_field("addr_ok", 32'(oldest.addr_ok), 32'(rsp_bus.addr_ok));
        check_field("blocks_used", 32'(oldest.blocks_used), 32'(rsp_bus.blocks_used));
        check_field("blocks_free", 32'(oldest.blocks_free), 32'(rsp_bus.blocks_free));
        check_field("blocks_peak", 32'(oldest.blocks_peak), 32'(rsp_bus.blocks_peak));
        check_field("alloc_total", oldest.alloc_total, rsp_bus.alloc_total);
        check_field("free_total", oldest.free_total, rsp_bus.free_total);
        check_field("fail_total", oldest.fail_total, rsp_bus.fail_total);
      end
    end
  end

  // Result side: random runs of ready and of stall bursts, ready throughout once no_stall is set.
  initial begin
    bit level;
    int run_len;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      level = no_stall || ($urandom_range(0, 2) != 0);
      run_len = level ? $urandom_range(1, 60) : $urandom_range(1, 17);
      rsp_bus.ready <= level;
      repeat (run_len - 1) @(posedge clk);
    end
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    logic [31:0] rnd_base;
    errors = 0;
    no_stall = 1'b0;
    blk_used = '0;
    used_cnt = '0;
    peak_cnt = '0;
    n_alloc = '0;
    n_freed = '0;
    n_failed = '0;
    pool_base = POOL_BASE_RST;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_data <= POOL_BASE_RST;
    req_bus.valid <= 1'b0;
    req_bus.cmd <= CMD_ALLOC;
    req_bus.addr <= '0;

    // Fresh pool at the reset base; the first rows can be worked out by hand.
    script.push_back('{CMD_ALLOC, 32'h0000_0000, 1'b1,
                       known_result(ST_OK, 32'h2000_0000, 5'd0, 1'b0, 6'd1, 6'd1, 1, 0, 0)});
    script.push_back('{CMD_ALLOC, 32'h2000_0000, 1'b1,
                       known_result(ST_OK, 32'h2000_0040, 5'd1, 1'b1, 6'd2, 6'd2, 2, 0, 0)});
    script.push_back('{CMD_FREE, 32'h0000_0000, 1'b1,
                       known_result(ST_INVALID, 32'h0, 5'd0, 1'b0, 6'd2, 6'd2, 2, 0, 0)});
    script.push_back('{CMD_FREE, 32'h2000_0040, 1'b1,
                       known_result(ST_OK, 32'h0, 5'd1, 1'b1, 6'd1, 6'd2, 2, 1, 0)});
    // The same block freed a second time.
    script.push_back('{CMD_FREE, 32'h2000_0040, 1'b1,
                       known_result(ST_INVALID, 32'h0, 5'd1, 1'b1, 6'd1, 6'd2, 2, 1, 0)});
    script.push_back('{CMD_FREE, 32'h2000_0041, 1'b1,
                       known_result(ST_INVALID, 32'h0, 5'd0, 1'b0, 6'd1, 6'd2, 2, 1, 0)});
    script.push_back('{CMD_FREE, 32'h2000_0800, 1'b1,
                       known_result(ST_INVALID, 32'h0, 5'd0, 1'b0, 6'd1, 6'd2, 2, 1, 0)});
    script.push_back('{CMD_FREE, 32'h1FFF_FFC0, 1'b1,
                       known_result(ST_INVALID, 32'h0, 5'd0, 1'b0, 6'd1, 6'd2, 2, 1, 0)});
    script.push_back('{CMD_FREE, 32'h2000_07C0, 1'b1,
                       known_result(ST_INVALID, 32'h0, 5'd31, 1'b1, 6'd1, 6'd2, 2, 1, 0)});
    script.push_back('{CMD_FREE, 32'hFFFF_FFFF, 1'b1,
                       known_result(ST_INVALID, 32'h0, 5'd0, 1'b0, 6'd1, 6'd2, 2, 1, 0)});
    script.push_back('{CMD_ALLOC, 32'hFFFF_FFFF, 1'b1,
                       known_result(ST_OK, 32'h2000_0040, 5'd1, 1'b0, 6'd2, 6'd2, 3, 1, 0)});
    script.push_back('{CMD_FREE, 32'h2000_0000, 1'b1,
                       known_result(ST_OK, 32'h0, 5'd0, 1'b1, 6'd1, 6'd2, 3, 2, 0)});
    script.push_back('{CMD_ALLOC, 32'h2000_07C0, 1'b0, '0});
    script.push_back('{CMD_ALLOC, 32'h1234_5678, 1'b0, '0});
    script.push_back('{CMD_FREE, 32'h2000_0080, 1'b0, '0});
    script.push_back('{CMD_FREE, 32'h2000_0080, 1'b0, '0});
    script.push_back('{CMD_FREE, 32'h2000_07FF, 1'b0, '0});
    script.push_back('{CMD_FREE, 32'h5555_5555, 1'b0, '0});
    script.push_back('{CMD_FREE, 32'hAAAA_AAAA, 1'b0, '0});
    script.push_back('{CMD_ALLOC, 32'hAAAA_AAAA, 1'b0, '0});

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (script[i]) begin
      send_request(script[i].cmd, script[i].addr, script[i].typed, script[i].res);
    end

    // Base 0xFFFFFC00 wraps the pool through address 0, so block 16 sits at null.
    rnd_base = $urandom;
    if (rnd_base == 32'd0) rnd_base = 32'd1;
    run_phase(32'h0000_0001, 315, 1'b0);
    run_phase(32'hFFFF_FFFF, 315, 1'b0);
    run_phase(32'hFFFF_FC00, 315, 1'b0);
    run_phase(rnd_base, 315, 1'b0);
    run_phase(32'h8000_0000, 315, 1'b0);
    run_phase(POOL_BASE_RST, 315, 1'b1);

    drain_results();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* fixed_block_pool_allocator.f */
+incdir+design
design/fbpa_pkg.sv
design/fbpa_ifs.sv
design/fbpa_front.sv
design/fbpa_queue.sv
design/fbpa_back.sv
design/fixed_block_pool_allocator.sv
tb/tb_fixed_block_pool_allocator.sv
